>>> rtl/core/fpsv_pkg.sv
package fpsv_pkg;

	localparam int SigW     = 64;
	localparam int ExpW     = 12;
	localparam int DefSideW = 1;
	localparam int AlignMax = 39;

	localparam logic [31:0] QNaN   = 32'h7FC0_0000;
	localparam logic [31:0] PosInf = 32'h7F80_0000;

	// operand for the normalize/round unit: value = (-1)^sign * sig * 2^exp,
	// unless spec is set, in which case spec_bits is the result
	typedef struct packed {
		logic                   sign;
		logic [SigW-1:0]        sig;
		logic signed [ExpW-1:0] exp;
		logic                   spec;
		logic [31:0]            spec_bits;
	} nr_in_t;

	function automatic logic is_nan(input logic [31:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
	endfunction

	function automatic logic [23:0] unpack_sig(input logic [31:0] v);
		return (v[30:23] == 8'd0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
	endfunction

	// exponent of the significand's lsb
	function automatic logic signed [ExpW-1:0] unpack_exp(input logic [31:0] v);
		return (v[30:23] == 8'd0) ? -ExpW'(149) : $signed(ExpW'(v[30:23])) - ExpW'(150);
	endfunction

	function automatic logic [5:0] msb_pos(input logic [SigW-1:0] v);
		logic [5:0] p;
		p = 6'd0;
		for (int i = 0; i < SigW; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage

>>> rtl/core/fpsv_norm_round.sv
module fpsv_norm_round #(
	parameter int SIDE_W = fpsv_pkg::DefSideW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  fpsv_pkg::nr_in_t   in_op,
	input  logic [SIDE_W-1:0]  in_side,
	output logic               out_valid,
	output logic [31:0]        out_bits,
	output logic [SIDE_W-1:0]  out_side
);

	localparam int EW = fpsv_pkg::ExpW;

	// stage A: leading one and shift amount
	logic                  valid_s1;
	fpsv_pkg::nr_in_t      op_s1;
	logic signed [EW-1:0]  sh_s1;
	logic [SIDE_W-1:0]     side_s1;

	logic [5:0]            p_c;
	logic signed [EW-1:0]  shift_c, lim_c, sh_c;

	always_comb begin
		p_c     = fpsv_pkg::msb_pos(in_op.sig);
		shift_c = $signed(EW'(p_c)) - EW'(23);
		lim_c   = -EW'(149) - in_op.exp;
		sh_c    = (lim_c > shift_c) ? lim_c : shift_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= in_op;
			sh_s1   <= sh_c;
			side_s1 <= in_side;
		end
	end

	// stage B: shift, round to nearest even, pack
	logic [127:0]          ext_c;
	logic [6:0]            rs_c;
	logic [24:0]           m_c;
	logic signed [EW-1:0]  e2_c, biased_c;
	logic                  ru_c;
	logic [31:0]           res_c;

	always_comb begin
		ext_c = '0;
		rs_c  = '0;
		ru_c  = 1'b0;
		e2_c  = op_s1.exp + sh_s1;
		if (sh_s1 <= 0) begin
			m_c = 25'(op_s1.sig << 5'(-sh_s1));
		end else begin
			rs_c  = (sh_s1 > EW'(127)) ? 7'd127 : 7'(sh_s1);
			ext_c = {op_s1.sig, 64'd0} >> rs_c;
			ru_c  = ext_c[63] & ((|ext_c[62:0]) | ext_c[64]);
			m_c   = 25'(ext_c[127:64]) + 25'(ru_c);
		end
		if (m_c[24]) begin
			m_c  = m_c >> 1;
			e2_c = e2_c + EW'(1);
		end
		biased_c = e2_c + EW'(150);
		if (op_s1.spec) begin
			res_c = op_s1.spec_bits;
		end else if (m_c == 25'd0) begin
			res_c = {op_s1.sign, 31'd0};
		end else if (m_c[23]) begin
			if (biased_c >= EW'(255)) res_c = {op_s1.sign, 31'd0} | fpsv_pkg::PosInf;
			else res_c = {op_s1.sign, 8'(biased_c), m_c[22:0]};
		end else begin
			res_c = {op_s1.sign, 8'd0, m_c[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_bits <= res_c;
			out_side <= side_s1;
		end
	end

endmodule

>>> rtl/core/fp32_scaled_vector_add.sv
// An input transfer passes stages s1 through s7 before its result is valid.
// Throughput: one element per cycle; the whole pipeline advances together
// whenever the output register is empty or its result is taken.
// Reset clears all valid bits and sets the scale register to +0.0.
// The scale register accepts a write every cycle.
module fp32_scaled_vector_add (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] scale_bits,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] x_bits,
	input  logic [31:0] y_bits,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sum_bits,
	output logic        last_out
);

	localparam int EW = fpsv_pkg::ExpW;

	logic en;
	logic [31:0] scale_q;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= '0;
		end else if (cfg_valid) begin
			scale_q <= scale_bits;
		end
	end

	// s1: multiply significands
	logic             valid_s1;
	fpsv_pkg::nr_in_t mop_s1;
	logic [32:0]      side_s1;
	fpsv_pkg::nr_in_t mop_c;
	logic             msign_c;
	logic [47:0]      mprod_c;

	always_comb begin
		msign_c        = scale_q[31] ^ x_bits[31];
		mprod_c        = fpsv_pkg::unpack_sig(scale_q) * fpsv_pkg::unpack_sig(x_bits);
		mop_c.sign     = msign_c;
		mop_c.sig      = 64'(mprod_c);
		mop_c.exp      = fpsv_pkg::unpack_exp(scale_q) + fpsv_pkg::unpack_exp(x_bits);
		mop_c.spec     = 1'b0;
		mop_c.spec_bits = '0;
		if (fpsv_pkg::is_nan(scale_q) || fpsv_pkg::is_nan(x_bits)) begin
			mop_c.spec      = 1'b1;
			mop_c.spec_bits = fpsv_pkg::QNaN;
		end else if (fpsv_pkg::is_inf(scale_q) || fpsv_pkg::is_inf(x_bits)) begin
			mop_c.spec = 1'b1;
			if (scale_q[30:0] == 31'd0 || x_bits[30:0] == 31'd0)
				mop_c.spec_bits = fpsv_pkg::QNaN;
			else
				mop_c.spec_bits = {msign_c, 31'd0} | fpsv_pkg::PosInf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mop_s1  <= mop_c;
			side_s1 <= {y_bits, is_last};
		end
	end

	// s2, s3: round product
	logic        valid_s3;
	logic [31:0] prod_s3;
	logic [32:0] side_s3;

	fpsv_norm_round #(.SIDE_W(33)) u_mul_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.in_op     (mop_s1),
		.in_side   (side_s1),
		.out_valid (valid_s3),
		.out_bits  (prod_s3),
		.out_side  (side_s3)
	);

	// s4: order operands and align
	logic                 valid_s4, last_s4;
	logic [63:0]          big_s4, small_s4;
	logic signed [EW-1:0] e_s4;
	logic                 sgnb_s4, sgns_s4, spec_s4;
	logic [31:0]          specb_s4;

	logic [31:0]          a_c, b_c;
	logic [23:0]          sa_c, sb_c, bg_c, sm_c;
	logic signed [EW-1:0] ea_c, eb_c, ed_c, emin_c;
	logic [8:0]           diff_c;
	logic [7:0]           k_c;
	logic [6:0]           kk_c;
	logic [127:0]         ext_c;
	logic [63:0]          bigal_c, smal_c;
	logic signed [EW-1:0] eal_c;
	logic                 sgnb_c, sgns_c, spec_c;
	logic [31:0]          specb_c;

	always_comb begin
		a_c  = prod_s3;
		b_c  = side_s3[32:1];
		sa_c = fpsv_pkg::unpack_sig(a_c);
		sb_c = fpsv_pkg::unpack_sig(b_c);
		ea_c = fpsv_pkg::unpack_exp(a_c);
		eb_c = fpsv_pkg::unpack_exp(b_c);
		if (ea_c >= eb_c) begin
			bg_c = sa_c; sm_c = sb_c; emin_c = eb_c; ed_c = ea_c - eb_c;
			sgnb_c = a_c[31]; sgns_c = b_c[31];
		end else begin
			bg_c = sb_c; sm_c = sa_c; emin_c = ea_c; ed_c = eb_c - ea_c;
			sgnb_c = b_c[31]; sgns_c = a_c[31];
		end
		diff_c = 9'(ed_c);
		k_c    = '0;
		kk_c   = '0;
		ext_c  = '0;
		if (diff_c <= 9'(fpsv_pkg::AlignMax)) begin
			bigal_c = 64'(bg_c) << diff_c[5:0];
			smal_c  = 64'(sm_c);
			eal_c   = emin_c;
		end else begin
			// far apart: small shifts right by the excess, its lost bits ORed into a sticky bit
			k_c     = 8'(diff_c - 9'(fpsv_pkg::AlignMax));
			kk_c    = (k_c >= 8'd64) ? 7'd64 : k_c[6:0];
			ext_c   = {64'(sm_c), 64'd0} >> kk_c;
			bigal_c = 64'(bg_c) << fpsv_pkg::AlignMax;
			smal_c  = ext_c[127:64] | 64'(|ext_c[63:0]);
			eal_c   = emin_c + EW'(k_c);
		end
		spec_c  = 1'b0;
		specb_c = '0;
		if (fpsv_pkg::is_nan(a_c) || fpsv_pkg::is_nan(b_c)) begin
			spec_c  = 1'b1;
			specb_c = fpsv_pkg::QNaN;
		end else if (fpsv_pkg::is_inf(a_c) || fpsv_pkg::is_inf(b_c)) begin
			spec_c = 1'b1;
			if (fpsv_pkg::is_inf(a_c) && fpsv_pkg::is_inf(b_c) && (a_c[31] != b_c[31]))
				specb_c = fpsv_pkg::QNaN;
			else
				specb_c = fpsv_pkg::is_inf(a_c) ? a_c : b_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s4   <= bigal_c;
			small_s4 <= smal_c;
			e_s4     <= eal_c;
			sgnb_s4  <= sgnb_c;
			sgns_s4  <= sgns_c;
			spec_s4  <= spec_c;
			specb_s4 <= specb_c;
			last_s4  <= side_s3[0];
		end
	end

	// s5: add or subtract magnitudes
	logic             valid_s5, last_s5;
	fpsv_pkg::nr_in_t aop_s5;
	fpsv_pkg::nr_in_t aop_c;

	always_comb begin
		aop_c.exp       = e_s4;
		aop_c.spec      = spec_s4;
		aop_c.spec_bits = specb_s4;
		if (sgnb_s4 == sgns_s4) begin
			aop_c.sign = sgnb_s4;
			aop_c.sig  = big_s4 + small_s4;
		end else if (big_s4 > small_s4) begin
			aop_c.sign = sgnb_s4;
			aop_c.sig  = big_s4 - small_s4;
		end else if (small_s4 > big_s4) begin
			aop_c.sign = sgns_s4;
			aop_c.sig  = small_s4 - big_s4;
		end else begin
			// exact cancellation gives +0
			aop_c.sign = 1'b0;
			aop_c.sig  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aop_s5  <= aop_c;
			last_s5 <= last_s4;
		end
	end

	// s6, s7: round sum into the output register
	fpsv_norm_round #(.SIDE_W(1)) u_add_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.in_op     (aop_s5),
		.in_side   (last_s5),
		.out_valid (out_valid),
		.out_bits  (sum_bits),
		.out_side  (last_out)
	);

endmodule
